@@ hdl/swsm_pkg.sv @@
// shared types, constants and helpers for the sliding window sum and min/max block
`default_nettype none
package swsm_pkg;

  // largest window the store can hold
  localparam int WINDOW_MAX = 64;
  // effective window bound and derived widths
  localparam int LEN_CAP = (WINDOW_MAX < 64) ? WINDOW_MAX : 64;
  localparam int PTR_W   = $clog2(LEN_CAP);
  localparam int CNT_W   = $clog2(LEN_CAP + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NARROW     = 2'd1;
  localparam logic [6:0] WINDOW_LEN_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_MAX  = 2'd1,
    OP_MIN  = 2'd2,
    OP_BAD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_OP = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT_RD,
    S_EVICT_SUB,
    S_PUSH,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [63:0] sample;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [6:0]         fill_count;
    logic               is_full;
    logic signed [63:0] window_sum;
    logic signed [63:0] extreme_value;
    logic [5:0]         extreme_index;
  } out_item_t;

  // wrap a value to 32 bits with sign extension when narrow
  function automatic logic [63:0] wrap_value(input logic [63:0] v, input logic narrow);
    return narrow ? {{32{v[31]}}, v[31:0]} : v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sliding_window_sum_minmax.sv @@
// sliding window moving sum with min/max query over a ring store
// sequence: push adds and writes, then registers the result while filling; once full (read, subtract, add, result);
//   a query scans the held samples, one stored sample a cycle through the single store read port;
//   an invalid op or empty query goes straight to the result
// throughput: one request at a time, next request taken as soon as the result is registered
// reset: synchronous, clears fill count, oldest pointer and sum; window_len 64, narrow_mode 0;
//   the sample store is not cleared, only held entries are read
`default_nettype none
module sliding_window_sum_minmax
  import swsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item
);

  // configuration and window state
  logic [6:0]         window_len;
  logic               narrow_mode;
  logic [PTR_W-1:0]   oldest, oldest_next;
  logic [CNT_W-1:0]   held, held_next;
  logic [63:0]        total, total_next;
  logic [CNT_W-1:0]   len;

  // sequencer and per-request registers
  state_t             state, state_next;
  op_t                cur_op;
  logic signed [63:0] cur_sample;
  status_t            cur_status, cur_status_next;
  logic [PTR_W-1:0]   scan_ptr, scan_ptr_next;
  logic [CNT_W-1:0]   issue_cnt, issue_cnt_next;
  logic               rd_pending, rd_pending_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic signed [63:0] best, best_next;
  logic [5:0]         best_idx, best_idx_next;
  logic               load_result;

  // store ports
  logic signed [63:0] store [LEN_CAP];
  logic               wr_en, rd_en;
  logic [PTR_W-1:0]   wr_addr, rd_addr;
  logic signed [63:0] rd_data;

  // shared adder and comparator
  logic               add_sub;
  logic [63:0]        add_b, add_raw, add_res;
  logic               better;
  logic [CNT_W:0]     fill_pos;
  logic [PTR_W-1:0]   fill_addr;
  logic [PTR_W-1:0]   oldest_inc, scan_inc;

  // effective window length
  always_comb begin
    if (window_len == '0) begin
      len = CNT_W'(1);
    end else if (window_len > 7'(LEN_CAP)) begin
      len = CNT_W'(LEN_CAP);
    end else begin
      len = CNT_W'(window_len);
    end
  end

  // pointer helpers
  always_comb begin
    fill_pos = (CNT_W + 1)'(oldest) + (CNT_W + 1)'(held);
    if (fill_pos >= (CNT_W + 1)'(len)) begin
      fill_pos = fill_pos - (CNT_W + 1)'(len);
    end
    fill_addr  = PTR_W'(fill_pos);
    oldest_inc = (CNT_W'(oldest) + CNT_W'(1) >= len) ? '0 : oldest + PTR_W'(1);
    scan_inc   = (CNT_W'(scan_ptr) + CNT_W'(1) >= len) ? '0 : scan_ptr + PTR_W'(1);
  end

  // adder: subtract evicted sample or add new one
  always_comb begin
    add_sub = (state == S_EVICT_SUB);
    add_b   = add_sub ? rd_data : cur_sample;
    add_raw = add_sub ? total - add_b : total + add_b;
    add_res = wrap_value(add_raw, narrow_mode);
    better  = (cur_op == OP_MAX) ? (rd_data > best) : (rd_data < best);
  end

  // next state and datapath control
  always_comb begin
    state_next      = state;
    oldest_next     = oldest;
    held_next       = held;
    total_next      = total;
    cur_status_next = cur_status;
    scan_ptr_next   = scan_ptr;
    issue_cnt_next  = issue_cnt;
    rd_pending_next = 1'b0;
    rd_idx_next     = rd_idx;
    best_next       = best;
    best_idx_next   = best_idx;
    wr_en           = 1'b0;
    wr_addr         = fill_addr;
    rd_en           = 1'b0;
    rd_addr         = oldest;
    in_ready        = 1'b0;
    load_result     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_status_next = ST_OK;
          best_next       = '0;
          best_idx_next   = '0;
          scan_ptr_next   = oldest;
          issue_cnt_next  = '0;
          unique case (in_item.op)
            OP_PUSH: state_next = (held < len) ? S_PUSH : S_EVICT_RD;
            OP_MAX, OP_MIN: begin
              if (held == '0) begin
                cur_status_next = ST_EMPTY;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              cur_status_next = ST_BAD_OP;
              state_next      = S_DONE;
            end
          endcase
        end
      end
      S_EVICT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = oldest;
        state_next = S_EVICT_SUB;
      end
      S_EVICT_SUB: begin
        total_next = add_res;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        wr_en      = 1'b1;
        total_next = add_res;
        if (held < len) begin
          wr_addr   = fill_addr;
          held_next = held + CNT_W'(1);
        end else begin
          wr_addr     = oldest;
          oldest_next = oldest_inc;
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        // issue one read a cycle, compare the sample read the cycle before
        if (issue_cnt < held) begin
          rd_en           = 1'b1;
          rd_addr         = scan_ptr;
          scan_ptr_next   = scan_inc;
          issue_cnt_next  = issue_cnt + CNT_W'(1);
          rd_pending_next = 1'b1;
          rd_idx_next     = issue_cnt;
        end
        if (rd_pending) begin
          if (rd_idx == '0 || better) begin
            best_next     = rd_data;
            best_idx_next = 6'(rd_idx);
          end
          if (rd_idx == held - CNT_W'(1)) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_result = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // a write to window_len or narrow_mode empties the window
    if (cfg_we && (cfg_idx == CFG_WINDOW_LEN || cfg_idx == CFG_NARROW)) begin
      oldest_next = '0;
      held_next   = '0;
      total_next  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_len  <= WINDOW_LEN_RESET;
      narrow_mode <= 1'b0;
      oldest      <= '0;
      held        <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
      rd_pending  <= 1'b0;
    end else begin
      state      <= state_next;
      oldest     <= oldest_next;
      held       <= held_next;
      total      <= total_next;
      rd_pending <= rd_pending_next;
      if (cfg_we && cfg_idx == CFG_WINDOW_LEN) begin
        window_len <= cfg_data[6:0];
      end
      if (cfg_we && cfg_idx == CFG_NARROW) begin
        narrow_mode <= cfg_data[0];
      end
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-request payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_op     <= in_item.op;
      cur_sample <= wrap_value(in_item.sample, narrow_mode);
    end
    cur_status <= cur_status_next;
    scan_ptr   <= scan_ptr_next;
    issue_cnt  <= issue_cnt_next;
    rd_idx     <= rd_idx_next;
    best       <= best_next;
    best_idx   <= best_idx_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_result) begin
      out_item.status        <= cur_status;
      out_item.fill_count    <= 7'(held);
      out_item.is_full       <= (held == len);
      out_item.window_sum    <= total;
      out_item.extreme_value <= best;
      out_item.extreme_index <= best_idx;
    end
  end

  // sample store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= cur_sample;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // fill count never passes the window length
  a_held_bound: assert property (@(posedge clk) disable iff (rst) held <= len)
    else $error("fill count above window length");

  // oldest pointer stays inside the window
  a_oldest_bound: assert property (@(posedge clk) disable iff (rst) CNT_W'(oldest) < len)
    else $error("oldest pointer outside window");

  // narrow sum is always a sign-extended 32-bit value
  a_narrow_sum: assert property (@(posedge clk) disable iff (rst)
    narrow_mode |-> (total[63:32] == {32{total[31]}}))
    else $error("narrow sum not sign extended");

  // scan never reads more samples than held
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> issue_cnt <= held)
    else $error("scan overran held samples");

  // a taken result leaves the output empty unless a new one is loaded
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && state != S_DONE) |=> !out_valid)
    else $error("result repeated after being taken");

endmodule
`default_nettype wire
